[design/hcd_pkg.sv]
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, codes and scoring function for the hall call dispatcher.
// ----------------------------------------------------------------------------
package hcd_pkg;

  // port field widths
  localparam int FLOOR_W  = 3;
  localparam int MOTION_W = 2;

  // internal floor width, wide enough for a top slot floor of up to 31
  localparam int SLOT_FLOOR_W = 5;

  // score width: largest penalty plus largest distance
  localparam int SCORE_W = 7;

  localparam logic [SCORE_W-1:0] PENALTY_PASSED   = 7'd10;
  localparam logic [SCORE_W-1:0] PENALTY_OPPOSITE = 7'd20;

  // input stream data width, padded to whole bytes
  localparam int IN_BITS = 2 * FLOOR_W + 2 * MOTION_W + FLOOR_W + 4;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_UPDATE   = 1'b1
  } op_t;

  typedef enum logic [MOTION_W-1:0] {
    MOTION_IDLE  = 2'd0,
    MOTION_UP    = 2'd1,
    MOTION_DOWN  = 2'd2,
    MOTION_OTHER = 2'd3
  } motion_t;

  typedef enum logic [1:0] {
    OWNER_NONE = 2'd0,
    OWNER_A    = 2'd1,
    OWNER_B    = 2'd2
  } owner_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    motion_t            motion;
    logic               door_open;
  } car_t;

  typedef struct packed {
    op_t                op;
    logic [FLOOR_W-1:0] hall_floor;
    logic               call_up;
    logic               link_fault;
    car_t               car_a;
    car_t               car_b;
  } item_t;

  // distance score of one car for one call
  function automatic logic [SCORE_W-1:0] car_score(
    input logic [SLOT_FLOOR_W-1:0] car_floor,
    input motion_t                 motion,
    input logic [SLOT_FLOOR_W-1:0] hall_floor,
    input logic                    up
  );
    logic [SLOT_FLOOR_W-1:0] span;
    logic [SCORE_W-1:0]      d;
    logic [SCORE_W-1:0]      score;
    span = (car_floor > hall_floor) ? (car_floor - hall_floor)
                                    : (hall_floor - car_floor);
    d = SCORE_W'(span);
    if (motion == MOTION_IDLE) begin
      score = d;
    end else if (motion == MOTION_UP && up) begin
      score = (car_floor < hall_floor) ? d : (PENALTY_PASSED + d);
    end else if (motion == MOTION_DOWN && !up) begin
      score = (car_floor > hall_floor) ? d : (PENALTY_PASSED + d);
    end else begin
      score = PENALTY_OPPOSITE + d;
    end
    return score;
  endfunction

endpackage

[design/hcd_core.sv]
// ----------------------------------------------------------------------------
// hcd_core
// Call table state and the per-slot register, assign and clear logic.
// ----------------------------------------------------------------------------
module hcd_core #(
  parameter int FLOORS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  hcd_pkg::item_t              item,
  output logic [2*(FLOORS-1)-1:0]     active_next,
  output logic [2*(FLOORS-1)-1:0]     owner_a_next,
  output logic [2*(FLOORS-1)-1:0]     owner_b_next,
  output logic [hcd_pkg::FLOOR_W-1:0] handoff_next
);

  localparam int SLOTS = 2 * (FLOORS - 1);
  localparam int FW    = hcd_pkg::SLOT_FLOOR_W;

  // call table
  logic [SLOTS-1:0]               active;
  hcd_pkg::owner_t                owner [SLOTS];
  logic [hcd_pkg::FLOOR_W-1:0]    handoff_floor;

  hcd_pkg::owner_t                owner_nx [SLOTS];
  logic [SLOTS-1:0]               to_b_now;
  logic [FW-1:0]                  slot_fl [SLOTS];

  logic [FW-1:0]                  a_floor;
  logic [FW-1:0]                  b_floor;
  logic                           is_update;

  assign a_floor   = FW'(item.car_a.floor);
  assign b_floor   = FW'(item.car_b.floor);
  assign is_update = (item.op == hcd_pkg::OP_UPDATE);

  // one slot of logic per call, all slots in parallel
  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    localparam logic         SLOT_UP = ((k % 2) == 0);
    localparam logic [FW-1:0] SLOT_FL =
      FW'(((k % 2) == 1) ? ((k + 1) / 2 + 1) : (k / 2 + 1));

    logic [hcd_pkg::SCORE_W-1:0] score_a;
    logic [hcd_pkg::SCORE_W-1:0] score_b;
    logic                        reg_hit;
    logic                        assign_now;
    logic                        pick_b;
    hcd_pkg::owner_t             owner_mid;
    logic                        clear_now;

    assign slot_fl[k] = SLOT_FL;
    assign score_a = hcd_pkg::car_score(a_floor, item.car_a.motion, SLOT_FL, SLOT_UP);
    assign score_b = hcd_pkg::car_score(b_floor, item.car_b.motion, SLOT_FL, SLOT_UP);

    // register transaction matching this slot
    assign reg_hit = (item.op == hcd_pkg::OP_REGISTER) &&
                     (FW'(item.hall_floor) == SLOT_FL) && (item.call_up == SLOT_UP);

    // hand an unowned active call to a car, ties to A, and all calls to A on a link fault
    assign assign_now = is_update && active[k] && (owner[k] == hcd_pkg::OWNER_NONE);
    assign pick_b     = !item.link_fault && (score_a > score_b);
    assign owner_mid  = assign_now ? (pick_b ? hcd_pkg::OWNER_B : hcd_pkg::OWNER_A)
                                   : owner[k];
    assign to_b_now[k] = assign_now && pick_b;

    // clear when the owning car stands at the floor with doors open
    assign clear_now = is_update &&
      ((owner_mid == hcd_pkg::OWNER_A && a_floor == SLOT_FL && item.car_a.door_open) ||
       (owner_mid == hcd_pkg::OWNER_B && b_floor == SLOT_FL && item.car_b.door_open));

    always_comb begin
      owner_nx[k]    = clear_now ? hcd_pkg::OWNER_NONE : owner_mid;
      active_next[k] = active[k];
      if (clear_now) begin
        active_next[k] = 1'b0;
      end else if (reg_hit && owner[k] == hcd_pkg::OWNER_NONE) begin
        active_next[k] = 1'b1;
      end
      owner_a_next[k] = (owner_nx[k] == hcd_pkg::OWNER_A);
      owner_b_next[k] = (owner_nx[k] == hcd_pkg::OWNER_B);
    end
  end

  // last hand-off to car B wins, so the highest slot takes priority
  always_comb begin
    handoff_next = handoff_floor;
    for (int k = 0; k < SLOTS; k++) begin
      if (to_b_now[k]) begin
        handoff_next = slot_fl[k][hcd_pkg::FLOOR_W-1:0];
      end
    end
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= '0;
      handoff_floor <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        owner[k] <= hcd_pkg::OWNER_NONE;
      end
    end else if (en) begin
      active        <= active_next;
      handoff_floor <= handoff_next;
      for (int k = 0; k < SLOTS; k++) begin
        owner[k] <= owner_nx[k];
      end
    end
  end

endmodule

[design/hall_call_dispatcher.sv]
// Hall call dispatcher for two cars. Each input transaction is either a hall
// call registration or an update tick with both cars' status; every
// transaction yields exactly one result carrying the call table after it was
// applied. One transaction is accepted per clock cycle and its result appears
// on the master side in the next cycle; the single result register is the
// only stage, so throughput is set by how fast the master side drains it.
// ----------------------------------------------------------------------------
// hall_call_dispatcher
// Stream wrapper: input unpacking, result register and handshake.
// ----------------------------------------------------------------------------
module hall_call_dispatcher #(
  parameter int FLOORS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // slave side
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // hall_floor, call_up, link_fault, a_floor, a_motion, a_door_open,
  // b_floor, b_motion, b_door_open
  input  logic [hcd_pkg::IN_W-1:0]              s_tdata,
  // operation
  input  logic                                  s_tuser,
  // master side
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // active_mask, car_a_mask, car_b_mask, target_floor_b
  output logic [((6*(FLOORS-1)+3+7)/8)*8-1:0]  m_tdata
);

  localparam int SLOTS    = 2 * (FLOORS - 1);
  localparam int OUT_BITS = 3 * SLOTS + hcd_pkg::FLOOR_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int FLW      = hcd_pkg::FLOOR_W;
  localparam int MW       = hcd_pkg::MOTION_W;

  hcd_pkg::item_t         item;
  logic                   accept;
  logic [SLOTS-1:0]       active_next;
  logic [SLOTS-1:0]       owner_a_next;
  logic [SLOTS-1:0]       owner_b_next;
  logic [FLW-1:0]         handoff_next;
  logic [OUT_BITS-1:0]    result;

  // unpack the input transaction
  assign item.op                = hcd_pkg::op_t'(s_tuser);
  assign item.hall_floor        = s_tdata[FLW-1:0];
  assign item.call_up           = s_tdata[FLW];
  assign item.link_fault        = s_tdata[FLW+1];
  assign item.car_a.floor       = s_tdata[FLW+2 +: FLW];
  assign item.car_a.motion      = hcd_pkg::motion_t'(s_tdata[2*FLW+2 +: MW]);
  assign item.car_a.door_open   = s_tdata[2*FLW+MW+2];
  assign item.car_b.floor       = s_tdata[2*FLW+MW+3 +: FLW];
  assign item.car_b.motion      = hcd_pkg::motion_t'(s_tdata[3*FLW+MW+3 +: MW]);
  assign item.car_b.door_open   = s_tdata[3*FLW+2*MW+3];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  hcd_core #(
    .FLOORS (FLOORS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .en           (accept),
    .item         (item),
    .active_next  (active_next),
    .owner_a_next (owner_a_next),
    .owner_b_next (owner_b_next),
    .handoff_next (handoff_next)
  );

  assign result = {handoff_next, owner_b_next, owner_a_next, active_next};

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_W'(result);
    end
  end

endmodule

[design/hcd_checker.sv]
// ----------------------------------------------------------------------------
// hcd_assertions
// Port-level checks on the dispatcher's result stream.
// ----------------------------------------------------------------------------
module hcd_assertions #(
  parameter int FLOORS = 4
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [((6*(FLOORS-1)+3+7)/8)*8-1:0] m_tdata
);

  localparam int SLOTS = 2 * (FLOORS - 1);

  logic [SLOTS-1:0] act;
  logic [SLOTS-1:0] own_a;
  logic [SLOTS-1:0] own_b;
  logic [4:0]       tgt;

  assign act   = m_tdata[0 +: SLOTS];
  assign own_a = m_tdata[SLOTS +: SLOTS];
  assign own_b = m_tdata[2*SLOTS +: SLOTS];
  assign tgt   = 5'(m_tdata[3*SLOTS +: hcd_pkg::FLOOR_W]);

  // a call never belongs to both cars
  a_owner_disjoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((own_a & own_b) == '0))
    else $error("call owned by both cars");

  // an owned call is always active
  a_owned_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (((own_a | own_b) & ~act) == '0))
    else $error("owned call not active");

  // hand-off floor is a real floor or zero
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (tgt <= 5'(FLOORS)))
    else $error("hand-off floor out of range");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind hall_call_dispatcher hcd_assertions #(
  .FLOORS (FLOORS)
) u_hcd_assertions (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
